### sv/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants for the wildcard byte pattern scanner: port widths,
// configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSigLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSigHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCare    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLength  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBase    = 3'd4;

  // signature registers hold at most this many bytes
  localparam int unsigned SigRegBytes = 16;
  localparam int unsigned SigW        = 8 * SigRegBytes;
  localparam int unsigned CareW       = SigRegBytes;
  localparam int unsigned LenW        = 5;

  // payload widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 64;

  // parameter defaults
  localparam int unsigned SignatureMaxDef = 16;
  localparam int unsigned OffsetBitsDef   = 32;

  // depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

endpackage

### sv/wbps_front.sv
// ----------------------------------------------------------------------------
// wbps_front
// Accepts region bytes, keeps the sliding byte window, offset counter and
// reported flag, and decides per byte whether a result word is produced.
// ----------------------------------------------------------------------------
module wbps_front #(
  parameter int unsigned SIGNATURE_MAX = wbps_pkg::SignatureMaxDef,
  parameter int unsigned OFFSET_BITS   = wbps_pkg::OffsetBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wbps_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         last_byte_i,
  // configuration
  input  logic [wbps_pkg::SigW-1:0]    sig_i,
  input  logic [wbps_pkg::CareW-1:0]   care_i,
  input  logic [wbps_pkg::LenW-1:0]    len_i,
  // result word toward the queue
  output logic                         evt_valid_o,
  input  logic                         evt_ready_i,
  output logic                         evt_found_o,
  output logic [OFFSET_BITS:0]         evt_start_o
);

  localparam int unsigned LenLimit = (SIGNATURE_MAX < wbps_pkg::SigRegBytes) ?
                                     SIGNATURE_MAX : wbps_pkg::SigRegBytes;
  localparam int unsigned WinIdxW  = (SIGNATURE_MAX > 1) ? $clog2(SIGNATURE_MAX) : 1;
  localparam int unsigned SelW     = (WinIdxW > wbps_pkg::LenW) ? WinIdxW : wbps_pkg::LenW;
  localparam int unsigned CntW     = OFFSET_BITS + 1;

  logic [wbps_pkg::ByteW-1:0] win_q [SIGNATURE_MAX];
  logic [wbps_pkg::ByteW-1:0] win_d [SIGNATURE_MAX];
  logic [OFFSET_BITS-1:0]     offset_q, offset_d;
  logic                       reported_q, reported_d;

  logic            accept;
  logic [CntW-1:0] count;
  logic [SelW-1:0] sel;
  logic            sig_match;
  logic            len_ok;
  logic            hit;

  assign in_ready_o = evt_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // window as it stands once this byte has been shifted in
  always_comb begin
    win_d[0] = data_byte_i;
    for (int i = 1; i < SIGNATURE_MAX; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  // compare the cared signature bytes against the aligned window entries
  always_comb begin
    sig_match = 1'b1;
    sel       = '0;
    for (int k = 0; k < LenLimit; k++) begin
      sel = SelW'(len_i) - SelW'(k) - SelW'(1);
      if ((SelW'(k) < SelW'(len_i)) && care_i[k] &&
          (win_d[sel[WinIdxW-1:0]] != sig_i[8*k +: 8])) begin
        sig_match = 1'b0;
      end
    end
  end

  // match decision for this byte
  assign count  = {1'b0, offset_q} + CntW'(1);
  assign len_ok = (len_i != '0) && (len_i <= wbps_pkg::LenW'(LenLimit));
  assign hit    = !reported_q && len_ok && (count >= CntW'(len_i)) && sig_match;

  // result word: first match, or not-found at the region's last byte
  assign evt_valid_o = accept & (hit | (last_byte_i & !reported_q));
  assign evt_found_o = hit;
  assign evt_start_o = hit ? (count - CntW'(len_i)) : '0;

  // scan state next values
  always_comb begin
    if (last_byte_i) begin
      offset_d   = '0;
      reported_d = 1'b0;
    end else begin
      offset_d   = (offset_q == '1) ? offset_q : offset_q + OFFSET_BITS'(1);
      reported_d = reported_q | hit;
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      reported_q <= 1'b0;
      for (int i = 0; i < SIGNATURE_MAX; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      offset_q   <= offset_d;
      reported_q <= reported_d;
      for (int i = 0; i < SIGNATURE_MAX; i++) begin
        win_q[i] <= last_byte_i ? '0 : win_d[i];
      end
    end
  end

endmodule

### sv/wbps_queue.sv
// ----------------------------------------------------------------------------
// wbps_queue
// Small first-in first-out queue of result words between front and back.
// ----------------------------------------------------------------------------
module wbps_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = wbps_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/wbps_back.sv
// ----------------------------------------------------------------------------
// wbps_back
// Takes result words from the queue, forms the match address from the
// region base and holds the result in the output register.
// ----------------------------------------------------------------------------
module wbps_back #(
  parameter int unsigned OFFSET_BITS = wbps_pkg::OffsetBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // queue head
  input  logic                       evt_valid_i,
  output logic                       evt_ready_o,
  input  logic                       evt_found_i,
  input  logic [OFFSET_BITS:0]       evt_start_i,
  // configuration
  input  logic [wbps_pkg::AddrW-1:0] base_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [wbps_pkg::AddrW-1:0] match_address_o
);

  logic                       out_valid_q;
  logic                       found_q;
  logic [wbps_pkg::AddrW-1:0] addr_q, addr_d;
  logic                       load;

  assign evt_ready_o = !out_valid_q | out_ready_i;
  assign load        = evt_valid_i & evt_ready_o;

  // match address, zero for a not-found result
  assign addr_d = evt_found_i ? (base_i + wbps_pkg::AddrW'(evt_start_i)) : '0;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (evt_ready_o) begin
      out_valid_q <= evt_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= evt_found_i;
      addr_q  <= addr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule

### sv/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans a region one byte per word for the first place where a byte
// signature with wildcard positions matches.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : data_byte_i / last_byte_i with in_valid_i / in_ready_o.
//                 last_byte_i marks the final byte of a region.
//   out channel : found_o / match_address_o with out_valid_o / out_ready_i.
//                 one word per region: the first match (address of its first
//                 byte, region base added) or a not-found word at the last byte.
//   config port : cfg_we_i, cfg_index_i, cfg_data_i; write only while idle.
//   throughput  : one byte per cycle while in_ready_o is high; the window compare
//                 and the offset counter in the front stage take one byte each clock.
//   path        : a result word goes from the front stage into the queue, then
//                 through the address add into the output register.
//   stall       : a two-word queue and the output register absorb a stalled
//                 receiver; in_ready_o drops only when the queue is full.
//   reset       : clears configuration and control registers, window, offset and
//                 reported flag; the block takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int unsigned SIGNATURE_MAX = wbps_pkg::SignatureMaxDef,
  parameter int unsigned OFFSET_BITS   = wbps_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wbps_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          last_byte_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [wbps_pkg::AddrW-1:0]    match_address_o
);

  localparam int unsigned EvtW = OFFSET_BITS + 2;

  logic [wbps_pkg::SigW/2-1:0]  sig_low_q;
  logic [wbps_pkg::SigW/2-1:0]  sig_high_q;
  logic [wbps_pkg::CareW-1:0]   care_q;
  logic [wbps_pkg::LenW-1:0]    len_q;
  logic [wbps_pkg::AddrW-1:0]   base_q;

  logic                   f_valid, f_ready, f_found;
  logic [OFFSET_BITS:0]   f_start;
  logic                   q_valid, q_ready;
  logic [EvtW-1:0]        q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_low_q  <= '0;
      sig_high_q <= '0;
      care_q     <= '0;
      len_q      <= '0;
      base_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wbps_pkg::CfgSigLow:  sig_low_q  <= cfg_data_i;
        wbps_pkg::CfgSigHigh: sig_high_q <= cfg_data_i;
        wbps_pkg::CfgCare:    care_q     <= cfg_data_i[wbps_pkg::CareW-1:0];
        wbps_pkg::CfgLength:  len_q      <= cfg_data_i[wbps_pkg::LenW-1:0];
        wbps_pkg::CfgBase:    base_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: window, offset and match decision
  wbps_front #(
    .SIGNATURE_MAX (SIGNATURE_MAX),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .sig_i       ({sig_high_q, sig_low_q}),
    .care_i      (care_q),
    .len_i       (len_q),
    .evt_valid_o (f_valid),
    .evt_ready_i (f_ready),
    .evt_found_o (f_found),
    .evt_start_o (f_start)
  );

  // queue of result words
  wbps_queue #(
    .WIDTH (EvtW),
    .DEPTH (wbps_pkg::QueueDepthDef)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_found, f_start}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // back: address forming and output register
  wbps_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .evt_valid_i     (q_valid),
    .evt_ready_o     (q_ready),
    .evt_found_i     (q_data[EvtW-1]),
    .evt_start_i     (q_data[OFFSET_BITS:0]),
    .base_i          (base_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

endmodule

### bench/wildcard_byte_pattern_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_tb
// Feeds byte regions to the scanner and checks every result word against a
// behavioral scan of the same bytes. Directed regions cover register masking,
// zero and overlong lengths, wildcards, address wrap, a full 16-byte signature
// and matches after the first. Random regions with planted, broken and absent
// signatures then run under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_tb;

  localparam int unsigned SigMax      = wbps_pkg::SignatureMaxDef;
  localparam int unsigned OffW        = wbps_pkg::OffsetBitsDef;
  localparam int          CycleLimit  = 400000;
  localparam int          RandomBytes = 800;
  localparam int          DrainCycles = 4;
  // indexes past the last register, writes there are dropped
  localparam logic [wbps_pkg::CfgIdxW-1:0] CfgUnusedLo = 3'd5;
  localparam logic [wbps_pkg::CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  typedef struct packed {
    logic                       found;
    logic [wbps_pkg::AddrW-1:0] address;
  } scan_result_t;

  typedef enum {ReadyAlways, ReadyCoin, ReadySparse, ReadyPulse} ready_mode_e;

  // dut signals
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [wbps_pkg::ByteW-1:0]    data_byte_i = '0;
  logic                          last_byte_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          found_o;
  logic [wbps_pkg::AddrW-1:0]    match_address_o;

  // scan model: registers and per-region state
  logic [wbps_pkg::CfgDataW-1:0] sig_low_m, sig_high_m, base_m;
  logic [wbps_pkg::CareW-1:0]    care_m;
  logic [wbps_pkg::LenW-1:0]     length_m;
  logic [wbps_pkg::ByteW-1:0]    window_m [SigMax];
  logic [OffW-1:0]               offset_m;
  logic                          reported_m;

  scan_result_t               awaited_scan_results [$];
  logic [wbps_pkg::ByteW-1:0] region_bytes [$];

  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          bytes_sent      = 0;
  int          regions_sent    = 0;
  int          results_checked = 0;
  int          config_phases   = 0;
  int unsigned burst_left      = 0;
  bit          steady_input    = 1'b0;
  ready_mode_e ready_mode      = ReadyAlways;
  int unsigned ready_hold      = 0;

  wildcard_byte_pattern_scanner uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_address_o(match_address_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               awaited_scan_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern, picks a new random mode when its random hold runs out
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_hold = $urandom_range(8, 60);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      ReadyAlways: out_ready_i <= 1'b1;
      ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      ReadySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= ready_hold[1];
    endcase
  end

  task automatic report_mismatch(string what, logic [wbps_pkg::AddrW-1:0] got,
                                 logic [wbps_pkg::AddrW-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (awaited_scan_results.size() == 0) begin
        report_mismatch("unexpected result word, found/address", {63'd0, found_o},
                        match_address_o);
      end else begin
        want = awaited_scan_results.pop_front();
        if (found_o !== want.found)
          report_mismatch("found", {63'd0, found_o}, {63'd0, want.found});
        if (match_address_o !== want.address)
          report_mismatch("match_address", match_address_o, want.address);
      end
    end
  end

  function automatic void clear_scan_state();
    for (int i = 0; i < SigMax; i++) window_m[i] = '0;
    offset_m   = '0;
    reported_m = 1'b0;
  endfunction

  function automatic bit window_hit(int unsigned len);
    logic [wbps_pkg::SigW-1:0] sig;
    sig = {sig_high_m, sig_low_m};
    for (int k = 0; k < len; k++)
      if (care_m[k] && window_m[len-1-k] != sig[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // predict the result word, if any, caused by one accepted byte
  function automatic void predict_scan_step(logic [wbps_pkg::ByteW-1:0] b, logic is_last);
    logic [wbps_pkg::AddrW-1:0] count;
    int unsigned                len;
    scan_result_t               r;
    count = wbps_pkg::AddrW'(offset_m) + 1;
    len   = length_m;
    for (int i = SigMax - 1; i > 0; i--) window_m[i] = window_m[i-1];
    window_m[0] = b;
    if (offset_m != '1) offset_m++;
    if (!reported_m && len != 0 && len <= SigMax && len <= wbps_pkg::SigRegBytes
        && count >= len && window_hit(len)) begin
      reported_m = 1'b1;
      r.found    = 1'b1;
      r.address  = base_m + (count - len);
      awaited_scan_results = {awaited_scan_results, r};
    end
    if (is_last) begin
      if (!reported_m) begin
        r.found   = 1'b0;
        r.address = '0;
        awaited_scan_results = {awaited_scan_results, r};
      end
      clear_scan_state();
    end
  endfunction

  // register write, write enable stays high until close_writes
  task automatic write_reg(logic [wbps_pkg::CfgIdxW-1:0] idx,
                           logic [wbps_pkg::CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      wbps_pkg::CfgSigLow:  sig_low_m  = value;
      wbps_pkg::CfgSigHigh: sig_high_m = value;
      wbps_pkg::CfgCare:    care_m     = value[wbps_pkg::CareW-1:0];
      wbps_pkg::CfgLength:  length_m   = value[wbps_pkg::LenW-1:0];
      wbps_pkg::CfgBase:    base_m     = value;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_setting(logic [wbps_pkg::CfgDataW-1:0] lo,
                              logic [wbps_pkg::CfgDataW-1:0] hi,
                              logic [wbps_pkg::CfgDataW-1:0] care,
                              logic [wbps_pkg::CfgDataW-1:0] len,
                              logic [wbps_pkg::CfgDataW-1:0] base);
    write_reg(wbps_pkg::CfgSigLow, lo);
    write_reg(wbps_pkg::CfgSigHigh, hi);
    write_reg(wbps_pkg::CfgCare, care);
    write_reg(wbps_pkg::CfgLength, len);
    write_reg(wbps_pkg::CfgBase, base);
    close_writes();
    config_phases++;
  endtask

  // send one byte word; the sender runs in bursts with random gaps
  task automatic send_byte(logic [wbps_pkg::ByteW-1:0] b, logic is_last);
    int unsigned gap;
    if (!steady_input && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_scan_step(b, is_last);
    bytes_sent++;
    if (is_last) regions_sent++;
  endtask

  task automatic send_region();
    for (int i = 0; i < region_bytes.size(); i++)
      send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  // let every pending word out, then give the block its latency
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (awaited_scan_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // registers still at reset: zero length never matches
  task automatic test_zero_length();
    region_bytes = '{8'h00, 8'hFF};
    send_region();
    drain_results();
  endtask

  // oversized values are cut to register width, unused indexes ignored
  task automatic test_register_masking();
    write_reg(wbps_pkg::CfgLength, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(wbps_pkg::CfgCare, 64'hFFFF_FFFF_FFFF_0000);
    for (int idx = CfgUnusedLo; idx <= CfgUnusedHi; idx++)
      write_reg(wbps_pkg::CfgIdxW'(idx), {$urandom, $urandom});
    close_writes();
    region_bytes = '{8'h00};
    send_region();
    drain_results();
  endtask

  // all 16 bytes compared, match ends at the last byte
  task automatic test_full_signature();
    logic [wbps_pkg::SigW-1:0] sig;
    load_setting(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, 64'hFFFF, 64'd16, 64'd0);
    sig = {sig_high_m, sig_low_m};
    region_bytes.delete();
    for (int k = 0; k < wbps_pkg::SigRegBytes; k++)
      region_bytes = {region_bytes, sig[8*k +: 8]};
    send_region();
    drain_results();
  endtask

  // wildcard second byte, base wraps past the top, second hit stays silent
  task automatic test_wildcard_later_match();
    load_setting(64'h5A, 64'd0, 64'h1, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    region_bytes = '{8'h01, 8'h5A, 8'h33, 8'h5A, 8'h44};
    send_region();
    drain_results();
  endtask

  task automatic pick_random_setting();
    logic [wbps_pkg::CfgDataW-1:0] lo, hi, care, len, base;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = 64'($urandom_range(17, 31));
      2:       len = 64'd16;
      default: len = 64'($urandom_range(1, 16));
    endcase
    // junk above the length field
    if ($urandom_range(0, 1) == 0) len |= {$urandom, $urandom} & ~64'h1F;
    case ($urandom_range(0, 3))
      0:       care = 64'hFFFF;
      1:       care = 64'({$urandom, 16'h0000});
      default: care = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 4))
      0:       base = '0;
      1:       base = '1;
      2:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
      default: base = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 4) == 0)
      write_reg(wbps_pkg::CfgIdxW'($urandom_range(CfgUnusedLo, CfgUnusedHi)),
                {$urandom, $urandom});
    load_setting(lo, hi, care, len, base);
  endtask

  // random fill, mostly with a planted copy of the signature, sometimes broken
  task automatic build_random_region();
    logic [wbps_pkg::SigW-1:0] sig;
    int unsigned               n, len, start, k;
    bit                        narrow;
    sig    = {sig_high_m, sig_low_m};
    n      = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    narrow = ($urandom_range(0, 2) == 0);
    len    = length_m;
    region_bytes.delete();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, wbps_pkg::SigRegBytes - 1);
      region_bytes = {region_bytes,
                      (narrow ? sig[8*k +: 8] : wbps_pkg::ByteW'($urandom))};
    end
    if (len != 0 && len <= wbps_pkg::SigRegBytes && n >= len
        && $urandom_range(0, 9) < 7) begin
      start = $urandom_range(0, n - len);
      for (int j = 0; j < len; j++)
        if (care_m[j]) region_bytes[start + j] = sig[8*j +: 8];
      if ($urandom_range(0, 3) == 0) begin
        k = start + $urandom_range(0, len - 1);
        region_bytes[k] = region_bytes[k] ^ wbps_pkg::ByteW'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic test_random_regions();
    int stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      drain_results();
      pick_random_setting();
      steady_input = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        build_random_region();
        send_region();
      end
    end
    steady_input = 1'b0;
  endtask

  // main sequence
  initial begin
    sig_low_m  = '0;
    sig_high_m = '0;
    care_m     = '0;
    length_m   = '0;
    base_m     = '0;
    clear_scan_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_length();
    test_register_masking();
    test_full_signature();
    test_wildcard_later_match();
    test_random_regions();
    drain_results();
    $display("scanned %0d bytes in %0d regions under %0d register settings",
             bytes_sent, regions_sent, config_phases);
    $display("checked %0d result words, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
